@@ hw/rtl/hcec_pkg.sv @@
// shared types, widths and constant functions for the hamming encode/check block
// no dependencies; used by hcec_encoder, hcec_checker and the top level

package hcec_pkg;

  // field widths, fixed by the item format
  localparam int unsigned WordW = 64;
  localparam int unsigned LenW  = 7;
  localparam int unsigned SynW  = 7;
  localparam int unsigned CfgW  = 3;

  // number of parity groups that fit in a 64-bit codeword (positions 1, 2, .. 64)
  localparam int unsigned NumGroups = 7;

  // largest codeword length handled
  localparam int unsigned CODE_MAX = 64;

  // reset value of the check group count register
  localparam logic [CfgW-1:0] CheckGroupsRst = 3'd7;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] codeword;
    logic [LenW-1:0]  code_length;
    logic [SynW-1:0]  syndrome;
    logic             error_found;
  } result_t;

  // smallest p with 2^p - p - 1 >= len, saturating at 8
  function automatic logic [3:0] parity_count(input logic [LenW-1:0] len);
    logic [3:0] p;
    p = 4'd0;
    for (int q = 0; q < 8; q++) begin
      if (int'(len) > (1 << q) - q - 1) begin
        p = p + 4'd1;
      end
    end
    return p;
  endfunction

  // largest data length whose codeword still fits in CODE_MAX positions
  function automatic int data_max();
    int best;
    best = 0;
    for (int l = 0; l < (1 << LenW); l++) begin
      if (l + int'(parity_count(LenW'(l))) <= int'(CODE_MAX)) begin
        best = l;
      end
    end
    return best;
  endfunction

  localparam int unsigned DataMax = data_max();

  function automatic logic is_pow2(input int pos);
    return (pos != 0) && ((pos & (pos - 1)) == 0);
  endfunction

  // number of powers of two in 1..pos
  function automatic int pow2_upto(input int pos);
    int cnt;
    cnt = 0;
    for (int k = 0; k < 8; k++) begin
      if ((1 << k) <= pos) begin
        cnt = cnt + 1;
      end
    end
    return cnt;
  endfunction

  // vector mask of the positions that belong to parity group grp
  function automatic logic [WordW-1:0] group_mask(input int grp);
    logic [WordW-1:0] m;
    m = '0;
    for (int pos = 1; pos <= int'(WordW); pos++) begin
      m[pos-1] = ((pos >> grp) & 1) != 0;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/hamming_code_encode_check_core.sv @@
// hamming encode / syndrome check core, even parity, codewords up to 64 positions
// an accepted item is registered in the input stage and then in the result stage
// throughput: one item per cycle unless stalled, set by the parity-tree pass between them
// reset: asynchronous active low, clears both stage valids; check group count resets to 7
// depends on hcec_pkg, hcec_encoder, hcec_checker

module hamming_code_encode_check_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel: number of parity groups used by checks
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hcec_pkg::CfgW-1:0]  cfg_data_i,
  // item input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [hcec_pkg::WordW-1:0] bits_i,
  input  logic [hcec_pkg::LenW-1:0]  length_i,
  // result output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [hcec_pkg::WordW-1:0] codeword_o,
  output logic [hcec_pkg::LenW-1:0]  code_length_o,
  output logic [hcec_pkg::SynW-1:0]  syndrome_o,
  output logic                       error_found_o
);

  // check group count register, always writable
  logic [hcec_pkg::CfgW-1:0] check_groups_q;

  // input stage
  logic                       s1_valid_q, s1_valid_d;
  logic                       kind_q;
  logic [hcec_pkg::WordW-1:0] bits_q;
  logic [hcec_pkg::LenW-1:0]  length_q;

  // result stage
  logic              out_valid_q, out_valid_d;
  hcec_pkg::result_t out_q, out_d;

  // pipeline control
  logic out_advance;
  logic s1_load;
  logic in_xfer;

  hcec_pkg::result_t enc_res;
  hcec_pkg::result_t chk_res;

  assign cfg_ready_o = 1'b1;

  // the result stage moves when it is empty or its transfer completes this cycle
  assign out_advance = !out_valid_q || !out_stall_i;
  // the input stage takes a new item when it is empty or hands its item on
  assign s1_load     = !s1_valid_q || out_advance;
  assign in_stall_o  = !s1_load;
  assign in_xfer     = in_valid_i && s1_load;

  assign s1_valid_d  = in_xfer ? 1'b1 : (out_advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_groups_q <= hcec_pkg::CheckGroupsRst;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        check_groups_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q   <= kind_i;
      bits_q   <= bits_i;
      length_q <= length_i;
    end
    if (out_advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  // both datapaths evaluate every item, the kind picks one
  hcec_encoder u_encoder (
    .bits_i   (bits_q),
    .length_i (length_q),
    .result_o (enc_res)
  );

  hcec_checker u_checker (
    .bits_i   (bits_q),
    .length_i (length_q),
    .groups_i (check_groups_q),
    .result_o (chk_res)
  );

  assign out_d = (kind_q == hcec_pkg::KIND_CHECK) ? chk_res : enc_res;

  assign out_valid_o   = out_valid_q;
  assign codeword_o    = out_q.codeword;
  assign code_length_o = out_q.code_length;
  assign syndrome_o    = out_q.syndrome;
  assign error_found_o = out_q.error_found;

  // error flag tracks the syndrome
  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_found_o == (syndrome_o != '0)))
    else $error("error flag does not match syndrome");

  // an encode result never carries a syndrome, a check result never carries a codeword
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_length_o == '0 || syndrome_o == '0))
    else $error("result mixes encode and check fields");

  // produced codeword never exceeds the maximum length
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_length_o <= hcec_pkg::LenW'(hcec_pkg::CODE_MAX)))
    else $error("codeword length above maximum");

  // zero-length codeword carries no bits
  a_empty_cw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && code_length_o == '0) |-> (codeword_o == '0))
    else $error("empty codeword has bits set");

  // an accepted item is held in the input stage in the next cycle
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted item lost at input stage");

  // with both stages full and the output stalled, the input must stall
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while pipeline full");

endmodule

@@ hw/rtl/hcec_encoder.sv @@
// hamming encoder: scatters data bits into non-power-of-two positions, fills parity bits
// depends on hcec_pkg

module hcec_encoder (
  input  logic [hcec_pkg::WordW-1:0] bits_i,
  input  logic [hcec_pkg::LenW-1:0]  length_i,
  output hcec_pkg::result_t          result_o
);

  logic [hcec_pkg::LenW-1:0]    len_c;
  logic [hcec_pkg::WordW-1:0]   data_m;
  logic [3:0]                   par_cnt;
  logic [hcec_pkg::LenW-1:0]    code_len;
  logic [hcec_pkg::WordW-1:0]   cw_data;
  logic [hcec_pkg::NumGroups-1:0] par;
  logic [hcec_pkg::WordW-1:0]   cw;

  // clamp so that data plus parity fits
  assign len_c = (length_i > hcec_pkg::LenW'(hcec_pkg::DataMax)) ?
                 hcec_pkg::LenW'(hcec_pkg::DataMax) : length_i;

  assign par_cnt  = hcec_pkg::parity_count(len_c);
  assign code_len = len_c + hcec_pkg::LenW'(par_cnt);

  always_comb begin
    for (int k = 0; k < int'(hcec_pkg::WordW); k++) begin
      data_m[k] = bits_i[k] & (len_c > hcec_pkg::LenW'(k));
    end
  end

  // fixed wiring: position pos takes data bit pos - 1 - (powers of two up to pos)
  always_comb begin
    int idx;
    idx     = 0;
    cw_data = '0;
    for (int pos = 1; pos <= int'(hcec_pkg::WordW); pos++) begin
      idx = pos - 1 - hcec_pkg::pow2_upto(pos);
      if (!hcec_pkg::is_pow2(pos)) begin
        cw_data[pos-1] = data_m[idx];
      end
    end
  end

  // even parity over each group, only for the groups in use
  always_comb begin
    for (int i = 0; i < int'(hcec_pkg::NumGroups); i++) begin
      par[i] = (par_cnt > 4'(i)) && (code_len >= hcec_pkg::LenW'(1 << i)) &&
               (^(cw_data & hcec_pkg::group_mask(i)));
    end
  end

  always_comb begin
    cw = cw_data;
    for (int i = 0; i < int'(hcec_pkg::NumGroups); i++) begin
      cw[(1 << i) - 1] = cw_data[(1 << i) - 1] | par[i];
    end
  end

  assign result_o.codeword    = cw;
  assign result_o.code_length = code_len;
  assign result_o.syndrome    = '0;
  assign result_o.error_found = 1'b0;

endmodule

@@ hw/rtl/hcec_checker.sv @@
// hamming syndrome checker over the configured number of parity groups
// depends on hcec_pkg

module hcec_checker (
  input  logic [hcec_pkg::WordW-1:0] bits_i,
  input  logic [hcec_pkg::LenW-1:0]  length_i,
  input  logic [hcec_pkg::CfgW-1:0]  groups_i,
  output hcec_pkg::result_t          result_o
);

  logic [hcec_pkg::LenW-1:0]  len_c;
  logic [hcec_pkg::WordW-1:0] word_m;
  logic [hcec_pkg::SynW-1:0]  syn;

  assign len_c = (length_i > hcec_pkg::LenW'(hcec_pkg::CODE_MAX)) ?
                 hcec_pkg::LenW'(hcec_pkg::CODE_MAX) : length_i;

  // positions past the codeword length read as zero
  always_comb begin
    for (int k = 0; k < int'(hcec_pkg::WordW); k++) begin
      word_m[k] = bits_i[k] & (len_c > hcec_pkg::LenW'(k));
    end
  end

  // syndrome bit i is the parity of group i
  always_comb begin
    for (int i = 0; i < int'(hcec_pkg::SynW); i++) begin
      syn[i] = (groups_i > hcec_pkg::CfgW'(i)) && (^(word_m & hcec_pkg::group_mask(i)));
    end
  end

  assign result_o.codeword    = '0;
  assign result_o.code_length = '0;
  assign result_o.syndrome    = syn;
  assign result_o.error_found = |syn;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for hamming_code_encode_check_core: encode and syndrome items
// checked against an in-bench hamming predictor; needs hcec_pkg and the core rtl only

module tb_top;

  // one row of the directed stimulus table; typed rows carry their own answer
  typedef struct {
    hcec_pkg::kind_e            kind;
    logic [hcec_pkg::WordW-1:0] bits;
    logic [hcec_pkg::LenW-1:0]  length;
    bit                         typed;
    hcec_pkg::result_t          want;
  } stim_row_t;

  localparam int unsigned ItemsPerSetting = 195;
  localparam int unsigned GapPct          = 12;
  localparam int unsigned HoldCycles      = 250;

  // group-count settings walked by the random part, extremes included
  localparam logic [hcec_pkg::CfgW-1:0] GroupPlan [9] = '{
    3'd7, 3'd0, 3'd5, 3'd7, 3'd1, 3'd3, 3'd6, 3'd2, 3'd4
  };

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [hcec_pkg::CfgW-1:0]  cfg_data_i    = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic                       kind_i        = 1'b0;
  logic [hcec_pkg::WordW-1:0] bits_i        = '0;
  logic [hcec_pkg::LenW-1:0]  length_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic [hcec_pkg::WordW-1:0] codeword_o;
  logic [hcec_pkg::LenW-1:0]  code_length_o;
  logic [hcec_pkg::SynW-1:0]  syndrome_o;
  logic                       error_found_o;

  // predictor copy of the group-count register, tracks every config transfer
  logic [hcec_pkg::CfgW-1:0]  check_groups  = hcec_pkg::CheckGroupsRst;
  hcec_pkg::result_t          pending_results [$];
  stim_row_t                  dir_rows [$];
  int                         mismatches    = 0;
  int                         results_seen  = 0;
  bit                         quiet_stretch = 1'b0;

  hamming_code_encode_check_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .bits_i        (bits_i),
    .length_i      (length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .codeword_o    (codeword_o),
    .code_length_o (code_length_o),
    .syndrome_o    (syndrome_o),
    .error_found_o (error_found_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // hamming predictor
  // ---------------------------------------------------------------------------

  // smallest p with 2^p - p - 1 >= dlen, capped at 8
  function automatic int unsigned parity_bits_for(input int unsigned dlen);
    int unsigned p;
    p = 0;
    while (p < 8 && ((1 << p) - p - 1) < dlen) p++;
    return p;
  endfunction

  // odd parity over positions 1..n whose index has bit grp set
  function automatic logic group_odd(input logic [hcec_pkg::WordW-1:0] word,
                                     input int unsigned n, input int unsigned grp);
    logic acc;
    acc = 1'b0;
    for (int unsigned pos = 1; pos <= n && pos <= hcec_pkg::WordW; pos++) begin
      if (((pos >> grp) & 1) != 0) acc ^= word[pos-1];
    end
    return acc;
  endfunction

  function automatic hcec_pkg::result_t hamming_predict(
      input hcec_pkg::kind_e kind, input logic [hcec_pkg::WordW-1:0] bits,
      input logic [hcec_pkg::LenW-1:0] length, input logic [hcec_pkg::CfgW-1:0] groups);
    hcec_pkg::result_t          r;
    int unsigned                len, p, n, j;
    logic [hcec_pkg::WordW-1:0] cw;
    r   = '0;
    len = length;
    if (kind == hcec_pkg::KIND_ENCODE) begin
      // too-long data is cut back until data plus parity fits the codeword
      while (len > 0 && len + parity_bits_for(len) > hcec_pkg::CODE_MAX) len--;
      p  = parity_bits_for(len);
      n  = len + p;
      j  = 0;
      cw = '0;
      // data fills the non power-of-two positions in order
      for (int unsigned pos = 1; pos <= n; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          cw[pos-1] = bits[j];
          j++;
        end
      end
      // each parity bit makes its group even
      for (int unsigned i = 0; i < p && i < hcec_pkg::NumGroups; i++) begin
        if ((1 << i) <= n && group_odd(cw, n, i)) cw[(1 << i) - 1] = 1'b1;
      end
      r.codeword    = cw;
      r.code_length = hcec_pkg::LenW'(n);
    end else begin
      if (len > hcec_pkg::CODE_MAX) len = hcec_pkg::CODE_MAX;
      for (int unsigned i = 0; i < groups; i++) begin
        if (group_odd(bits, len, i)) r.syndrome[i] = 1'b1;
      end
      r.error_found = (r.syndrome != '0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input hcec_pkg::kind_e kind, input logic [hcec_pkg::WordW-1:0] bits,
                         input logic [hcec_pkg::LenW-1:0] length, input bit typed,
                         input logic [hcec_pkg::WordW-1:0] cw,
                         input logic [hcec_pkg::LenW-1:0] clen,
                         input logic [hcec_pkg::SynW-1:0] syn, input logic err);
    stim_row_t row;
    row.kind   = kind;
    row.bits   = bits;
    row.length = length;
    row.typed  = typed;
    row.want   = '{codeword: cw, code_length: clen, syndrome: syn, error_found: err};
    dir_rows.push_back(row);
  endtask

  // offer one item, hold it until the transfer, then log what must come back
  task automatic send_item(input hcec_pkg::kind_e kind, input logic [hcec_pkg::WordW-1:0] bits,
                           input logic [hcec_pkg::LenW-1:0] length,
                           input hcec_pkg::result_t want);
    // random sender gaps, payload scrambled while valid is low
    while (!quiet_stretch && $urandom_range(99) < GapPct) begin
      in_valid_i <= 1'b0;
      bits_i     <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    bits_i     <= bits;
    length_i   <= length;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pending_results.push_back(want);
  endtask

  // drop valid, wait for every pending result, then let the pipe run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_groups(input logic [hcec_pkg::CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    check_groups = value;
  endtask

  // mostly encodes and checks of real codewords with 0, 1 or 2 flips; the rest noise
  task automatic pick_random_item(output hcec_pkg::kind_e kind,
                                  output logic [hcec_pkg::WordW-1:0] bits,
                                  output logic [hcec_pkg::LenW-1:0] length);
    int unsigned                sel, dlen;
    logic [hcec_pkg::WordW-1:0] mask;
    hcec_pkg::result_t          enc;
    sel  = $urandom_range(99);
    bits = {$urandom, $urandom};
    if (sel < 35) begin
      kind = hcec_pkg::KIND_ENCODE;
      dlen = $urandom_range(99);
      if (dlen < 5) length = '0;
      else if (dlen < 15) length = hcec_pkg::LenW'($urandom_range(58, 127));
      else length = hcec_pkg::LenW'($urandom_range(1, 57));
    end else if (sel < 80) begin
      kind   = hcec_pkg::KIND_CHECK;
      enc    = hamming_predict(hcec_pkg::KIND_ENCODE, bits,
                               hcec_pkg::LenW'($urandom_range(1, 57)), check_groups);
      length = enc.code_length;
      mask   = (64'd1 << enc.code_length) - 64'd1;
      // bits above the codeword are junk that must be ignored
      bits   = (enc.codeword & mask) | ({$urandom, $urandom} & ~mask);
      sel    = $urandom_range(99);
      if (sel >= 50) bits[$urandom_range(0, enc.code_length - 1)] ^= 1'b1;
      if (sel >= 90) bits[$urandom_range(0, enc.code_length - 1)] ^= 1'b1;
      if ($urandom_range(9) == 0) length = hcec_pkg::LenW'($urandom_range(0, 127));
    end else begin
      kind   = hcec_pkg::KIND_CHECK;
      length = hcec_pkg::LenW'($urandom_range(0, 127));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    hcec_pkg::kind_e            kind;
    logic [hcec_pkg::WordW-1:0] bits;
    logic [hcec_pkg::LenW-1:0]  length;

    // directed table, run at the reset group count of 7
    //      kind                  bits                   len    typed codeword clen syn err
    add_row(hcec_pkg::KIND_ENCODE, 64'd0,                  7'd0,   1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd0,   1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_ENCODE, 64'd1,                  7'd1,   1, 64'd7, 7'd3,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd1,   1, 64'd7, 7'd3,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_ENCODE, 64'd0,                  7'd57,  1, 64'd0, 7'd63, 7'd0,  1'b0);
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd57,  0, '0, '0, '0, 1'b0);
    // longest data lengths, clamped back to 57, then three other encodes
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd58,  0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd64,  0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_ENCODE, '1,                     7'd127, 0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_ENCODE, 64'hDEAD_BEEF_0BAD_F00D, 7'd4,   0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_ENCODE, 64'h0000_0000_0000_0555, 7'd11,  0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_ENCODE, 64'hA5A5_A5A5_A5A5_A5A5, 7'd26,  0, '0, '0, '0, 1'b0);
    // checks: zero length, all zeros, all ones, clamped length
    add_row(hcec_pkg::KIND_CHECK,  64'd0,                  7'd0,   1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_CHECK,  '1,                     7'd0,   1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_CHECK,  64'd0,                  7'd64,  1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_CHECK,  '1,                     7'd64,  1, 64'd0, 7'd0,  7'd64, 1'b1);
    add_row(hcec_pkg::KIND_CHECK,  '1,                     7'd127, 1, 64'd0, 7'd0,  7'd64, 1'b1);
    // single error at position 5, once clean and once with junk above the length
    add_row(hcec_pkg::KIND_CHECK,  64'h10,                 7'd7,   1, 64'd0, 7'd0,  7'd5,  1'b1);
    add_row(hcec_pkg::KIND_CHECK,  64'hFFFF_FFFF_FFFF_FF90, 7'd7,   1, 64'd0, 7'd0,  7'd5,  1'b1);
    // top position counts only while the codeword reaches it
    add_row(hcec_pkg::KIND_CHECK,  64'h8000_0000_0000_0000, 7'd64,  1, 64'd0, 7'd0,  7'd64, 1'b1);
    add_row(hcec_pkg::KIND_CHECK,  64'h8000_0000_0000_0000, 7'd63,  1, 64'd0, 7'd0,  7'd0,  1'b0);
    add_row(hcec_pkg::KIND_CHECK,  64'h0123_4567_89AB_CDEF, 7'd33,  0, '0, '0, '0, 1'b0);
    add_row(hcec_pkg::KIND_CHECK,  64'hF0F0_3C3C_5A5A_9669, 7'd100, 0, '0, '0, '0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].kind, dir_rows[k].bits, dir_rows[k].length,
                dir_rows[k].typed ? dir_rows[k].want
                                  : hamming_predict(dir_rows[k].kind, dir_rows[k].bits,
                                                    dir_rows[k].length, check_groups));
    end
    settle();

    // random part, one block of items per group-count setting
    foreach (GroupPlan[ph]) begin
      write_groups(GroupPlan[ph]);
      // one setting runs back to back on both sides
      quiet_stretch = (ph == 3);
      for (int unsigned k = 0; k < ItemsPerSetting; k++) begin
        pick_random_item(kind, bits, length);
        send_item(kind, bits, length, hamming_predict(kind, bits, length, check_groups));
      end
      settle();
    end

    // a few more cycles so a stray late result would still be caught
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: stall driver and checker
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input hcec_pkg::result_t want,
                               input hcec_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: want cw %h len %0d syn %0d err %0b, got cw %h len %0d syn %0d err %0b",
               $realtime, what, want.codeword, want.code_length, want.syndrome,
               want.error_found, got.codeword, got.code_length, got.syndrome, got.error_found);
    end
  endtask

  initial begin : result_side
    hcec_pkg::result_t got, want;
    int                hold_left;
    bit                held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got = '{codeword: codeword_o, code_length: code_length_o,
                syndrome: syndrome_o, error_found: error_found_o};
        results_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch("result transfer with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.codeword !== want.codeword || got.code_length !== want.code_length ||
              got.syndrome !== want.syndrome || got.error_found !== want.error_found) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      // one long hold-off lets the pipe fill and push back on the sender
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held && results_seen >= 400) begin
        held        = 1'b1;
        hold_left   = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_stretch && ($urandom_range(99) < GapPct);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hcec_pkg.sv
hw/rtl/hcec_encoder.sv
hw/rtl/hcec_checker.sv
hw/rtl/hamming_code_encode_check_core.sv
tb/tb_top.sv
